// ===== sv/scfp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scfp_pkg
// shared types and constants of the serial command frame parser
// ---------------------------------------------------------------------------
package scfp_pkg;

   // csr address map: register i at byte address 4*i
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   localparam logic [2:0] RegStartMarker    = 3'd0;
   localparam logic [2:0] RegEndMarker      = 3'd1;
   localparam logic [2:0] RegAcceptedType   = 3'd2;
   localparam logic [2:0] RegSetModeCode    = 3'd3;
   localparam logic [2:0] RegResetCountCode = 3'd4;
   localparam logic [2:0] RegMaxPayload     = 3'd5;

   // reset values of the registers
   localparam logic [7:0] RstStartMarker    = 8'd170;
   localparam logic [7:0] RstEndMarker      = 8'd85;
   localparam logic [7:0] RstAcceptedType   = 8'd1;
   localparam logic [7:0] RstSetModeCode    = 8'd1;
   localparam logic [7:0] RstResetCountCode = 8'd2;
   localparam logic [7:0] RstMaxPayload     = 8'd16;

   // command kinds of a result word
   localparam logic KindSetMode    = 1'b0;
   localparam logic KindResetCount = 1'b1;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] accepted_type;
      logic [7:0] set_mode_code;
      logic [7:0] reset_count_code;
      logic [7:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic       command_kind;
      logic [7:0] mode_value;
   } rsp_type;

endpackage

// ===== sv/scfp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scfp request and response channels
// valid/ready channels carrying one word per handshake
// ---------------------------------------------------------------------------
interface scfp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface scfp_rsp_if;
   logic       valid;
   logic       ready;
   logic       command_kind;
   logic [7:0] mode_value;

   modport source (output valid, output command_kind, output mode_value, input ready);
   modport sink   (input valid, input command_kind, input mode_value, output ready);
endinterface

// ===== sv/scfp_csr.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scfp_csr
// apb-style register file holding the frame parser configuration
// ---------------------------------------------------------------------------
module scfp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [scfp_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [scfp_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [scfp_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                 pready,
   output scfp_pkg::cfg_type                    cfg
);

   scfp_pkg::cfg_type cfg_ff;
   scfp_pkg::cfg_type cfg_in;
   logic [2:0]        reg_index;
   logic [7:0]        wr_byte;
   logic [7:0]        rd_byte;
   logic              wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_byte   = pwdata[7:0];
   assign wr_en     = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            scfp_pkg::RegStartMarker:    cfg_in.start_marker     = wr_byte;
            scfp_pkg::RegEndMarker:      cfg_in.end_marker       = wr_byte;
            scfp_pkg::RegAcceptedType:   cfg_in.accepted_type    = wr_byte;
            scfp_pkg::RegSetModeCode:    cfg_in.set_mode_code    = wr_byte;
            scfp_pkg::RegResetCountCode: cfg_in.reset_count_code = wr_byte;
            scfp_pkg::RegMaxPayload:     cfg_in.max_payload      = wr_byte;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         scfp_pkg::RegStartMarker:    rd_byte = cfg_ff.start_marker;
         scfp_pkg::RegEndMarker:      rd_byte = cfg_ff.end_marker;
         scfp_pkg::RegAcceptedType:   rd_byte = cfg_ff.accepted_type;
         scfp_pkg::RegSetModeCode:    rd_byte = cfg_ff.set_mode_code;
         scfp_pkg::RegResetCountCode: rd_byte = cfg_ff.reset_count_code;
         scfp_pkg::RegMaxPayload:     rd_byte = cfg_ff.max_payload;
         default:                     rd_byte = 8'd0;
      endcase
   end

   assign prdata = {{(scfp_pkg::CsrDataWidth-8){1'b0}}, rd_byte};
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker     <= scfp_pkg::RstStartMarker;
         cfg_ff.end_marker       <= scfp_pkg::RstEndMarker;
         cfg_ff.accepted_type    <= scfp_pkg::RstAcceptedType;
         cfg_ff.set_mode_code    <= scfp_pkg::RstSetModeCode;
         cfg_ff.reset_count_code <= scfp_pkg::RstResetCountCode;
         cfg_ff.max_payload      <= scfp_pkg::RstMaxPayload;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/scfp_parse.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scfp_parse
// frame phase machine, one byte per accepted word
// ---------------------------------------------------------------------------
module scfp_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              cmd,
   input  logic [7:0]        rx_byte,
   input  scfp_pkg::cfg_type cfg,
   output logic              hit,
   output scfp_pkg::rsp_type result
);

   localparam logic [2:0] PhStart   = 3'd0;
   localparam logic [2:0] PhType    = 3'd1;
   localparam logic [2:0] PhId      = 3'd2;
   localparam logic [2:0] PhLength  = 3'd3;
   localparam logic [2:0] PhPayload = 3'd4;
   localparam logic [2:0] PhEnd     = 3'd5;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] frame_code_ff, frame_code_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] seen_ff, seen_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] seen_inc;

   assign seen_inc = seen_ff + 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      frame_code_in = frame_code_ff;
      length_in     = length_ff;
      seen_in       = seen_ff;
      first_in      = first_ff;
      hit           = 1'b0;
      result        = '0;
      if (accept) begin
         if (cmd) begin
            phase_in  = PhStart;
            seen_in   = 8'd0;
            length_in = 8'd0;
         end else begin
            case (phase_ff)
               PhStart: begin
                  if (rx_byte == cfg.start_marker) begin
                     seen_in  = 8'd0;
                     phase_in = PhType;
                  end
               end
               PhType: begin
                  if (rx_byte == cfg.accepted_type) begin
                     phase_in = PhId;
                  end else begin
                     phase_in  = PhStart;
                     seen_in   = 8'd0;
                     length_in = 8'd0;
                  end
               end
               PhId: begin
                  frame_code_in = rx_byte;
                  phase_in      = PhLength;
               end
               PhLength: begin
                  if (rx_byte > cfg.max_payload) begin
                     phase_in  = PhStart;
                     seen_in   = 8'd0;
                     length_in = 8'd0;
                  end else begin
                     length_in = rx_byte;
                     seen_in   = 8'd0;
                     phase_in  = (rx_byte == 8'd0) ? PhEnd : PhPayload;
                  end
               end
               PhPayload: begin
                  if (seen_ff == 8'd0) first_in = rx_byte;
                  seen_in = seen_inc;
                  if (seen_inc >= length_ff) phase_in = PhEnd;
               end
               PhEnd: begin
                  if (rx_byte == cfg.end_marker) begin
                     if (frame_code_ff == cfg.set_mode_code && length_ff == 8'd1) begin
                        hit                 = 1'b1;
                        result.command_kind = scfp_pkg::KindSetMode;
                        result.mode_value   = first_ff;
                     end else if (frame_code_ff == cfg.reset_count_code &&
                                  length_ff == 8'd0) begin
                        hit                 = 1'b1;
                        result.command_kind = scfp_pkg::KindResetCount;
                        result.mode_value   = 8'd0;
                     end
                  end
                  phase_in  = PhStart;
                  seen_in   = 8'd0;
                  length_in = 8'd0;
               end
               default: begin
                  phase_in  = PhStart;
                  seen_in   = 8'd0;
                  length_in = 8'd0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PhStart;
         frame_code_ff <= 8'd0;
         length_ff     <= 8'd0;
         seen_ff       <= 8'd0;
         first_ff      <= 8'd0;
      end else begin
         phase_ff      <= phase_in;
         frame_code_ff <= frame_code_in;
         length_ff     <= length_in;
         seen_ff       <= seen_in;
         first_ff      <= first_in;
      end
   end

endmodule

// ===== sv/scfp_outq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scfp_outq
// result register with a skid stage behind it
// ---------------------------------------------------------------------------
module scfp_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  scfp_pkg::rsp_type push_data,
   output logic              space,
   output logic              out_valid,
   input  logic              out_ready,
   output scfp_pkg::rsp_type out_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   scfp_pkg::rsp_type main_ff, main_in;
   scfp_pkg::rsp_type skid_ff, skid_in;
   logic              pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== sv/serial_command_frame_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_command_frame_parser
// parses start/end delimited, length framed command frames from a byte stream
// ---------------------------------------------------------------------------
// One word enters per clock while req.ready is high: a received byte, or a
// flush that sends the parser back to waiting for a start byte. Frames are
// start byte, type, id, length, payload bytes and end byte; a wrong type or an
// over-long length abandons the frame on that byte, a wrong end byte drops it.
// A good frame yields one result word only for set mode (one payload byte) or
// reset count (no payload). A result goes to the result register, or to the
// skid while that is held, then out on rsp. A two-entry output stage (result
// register plus skid) lets input continue while a result waits; req.ready drops
// only when both entries are full. The user must write configuration over the
// apb-style port while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module serial_command_frame_parser (
   input  logic                              clock,
   input  logic                              reset,
   scfp_req_if.sink                          req,
   scfp_rsp_if.source                        rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [scfp_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [scfp_pkg::CsrDataWidth-1:0] pwdata,
   output logic [scfp_pkg::CsrDataWidth-1:0] prdata,
   output logic                              pready
);

   scfp_pkg::cfg_type cfg;
   scfp_pkg::rsp_type parse_result;
   scfp_pkg::rsp_type out_data;
   logic              req_accept;
   logic              parse_hit;
   logic              space;

   // configuration registers
   scfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input word accepted whenever the skid entry is free
   assign req.ready  = space;
   assign req_accept = req.valid && space;

   // frame phase machine
   scfp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .cmd     (req.cmd),
      .rx_byte (req.rx_byte),
      .cfg     (cfg),
      .hit     (parse_hit),
      .result  (parse_result)
   );

   // result register and skid
   scfp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (parse_hit),
      .push_data (parse_result),
      .space     (space),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (out_data)
   );

   assign rsp.command_kind = out_data.command_kind;
   assign rsp.mode_value   = out_data.mode_value;

   // a full skid entry means the result register is occupied too
   a_skid_implies_main: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid)
      else $error("skid entry full while result register empty");

   // only a byte word that closes a frame may produce a result
   a_no_result_on_flush: assert property (@(posedge clock) disable iff (reset)
      parse_hit |-> (req_accept && !req.cmd))
      else $error("result produced without an accepted byte");

   // no result is pending right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid after reset");

endmodule
